// ===== hw/rtl/urb_pkg.sv =====
// ----------------------------------------------------------------------------
// UART register block package
// Register offsets, bit masks, item kinds, receive FIFO sizing and the
// structures passed between the top level and the receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package urb_pkg;

    // Receive FIFO sizing.
    localparam int RX_DEPTH = 16;
    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

    // Item kinds.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    // Register byte offsets.
    localparam logic [7:0] OFF_SR  = 8'h00;
    localparam logic [7:0] OFF_DR  = 8'h04;
    localparam logic [7:0] OFF_BRR = 8'h08;
    localparam logic [7:0] OFF_CR1 = 8'h0C;

    // Status register bits.
    localparam logic [31:0] SR_TXE   = 32'h0000_0080;
    localparam logic [31:0] SR_TC    = 32'h0000_0040;
    localparam logic [31:0] SR_RXNE  = 32'h0000_0020;
    localparam logic [31:0] SR_RESET = SR_TXE | SR_TC;

    // Control register bits.
    localparam logic [31:0] CR1_UE     = 32'h0000_2000;
    localparam logic [31:0] CR1_TXEIE  = 32'h0000_0080;
    localparam logic [31:0] CR1_RXNEIE = 32'h0000_0020;

    // Low byte of a data register write.
    localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_fifo_req;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } t_fifo_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/urb_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// UART receive FIFO
// Ring buffer of received bytes. The head entry is kept in a register so
// that a pop sees its byte without a read in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module urb_rx_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire urb_pkg::t_fifo_req i_req,
    output urb_pkg::t_fifo_stat     o_stat,
    output logic [7:0]              o_head
);

    localparam logic [urb_pkg::RX_PTR_W-1:0] PTR_LAST =
        urb_pkg::RX_PTR_W'(urb_pkg::RX_DEPTH - 1);
    localparam logic [urb_pkg::RX_PTR_W-1:0] PTR_ONE  = urb_pkg::RX_PTR_W'(1);
    localparam logic [urb_pkg::RX_CNT_W-1:0] CNT_FULL =
        urb_pkg::RX_CNT_W'(urb_pkg::RX_DEPTH);
    localparam logic [urb_pkg::RX_CNT_W-1:0] CNT_ONE  = urb_pkg::RX_CNT_W'(1);

    logic [7:0]                   mem [urb_pkg::RX_DEPTH];
    logic [urb_pkg::RX_PTR_W-1:0] r_wr_ptr;
    logic [urb_pkg::RX_PTR_W-1:0] r_rd_ptr;
    logic [urb_pkg::RX_CNT_W-1:0] r_fill;
    logic [7:0]                   r_head;
    logic [urb_pkg::RX_PTR_W-1:0] n_rd_ptr;
    logic [urb_pkg::RX_PTR_W-1:0] n_wr_ptr;

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        if (i_req.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;
        end
        n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            if (i_req.push) begin
                r_wr_ptr <= n_wr_ptr;
                r_fill   <= r_fill + CNT_ONE;
            end else if (i_req.pop) begin
                r_fill   <= r_fill - CNT_ONE;
            end
        end
    end

    // The head register follows the entry at the next read pointer; a byte
    // written to that very entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            mem[r_wr_ptr] <= i_req.data;
        end
        if (i_req.push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_req.data;
        end else begin
            r_head <= mem[n_rd_ptr];
        end
    end

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == CNT_FULL);
    assign o_stat.last  = (r_fill == CNT_ONE);
    assign o_head       = r_head;

endmodule

`default_nettype wire

// ===== hw/rtl/uart_register_block_with_rx_fifo_core.sv =====
// ----------------------------------------------------------------------------
// UART register block with receive FIFO
// Each request is a bus read, a bus write, a received byte or a transmit
// tick, chosen by i_mode. The block holds SR, DR, BRR and CR1 and a ring
// FIFO of received bytes, and gives exactly one result per request.
// Both channels use valid and stall: a request is taken when valid is high
// and stall is low. A request is first captured in an input register; once
// the output register is empty or being emptied, it updates the registers
// and the FIFO and its result is loaded into the output register, which
// raises o_out_valid. One request per cycle is sustained while the receiver
// does not stall, set by the single read-modify-write pass over the
// register state. While the receiver stalls, the result waits in the output
// register and the input register still takes one further request; only
// then is o_in_stall raised.
// Reset (synchronous, active low) sets SR to TXE and TC, clears the other
// registers, empties the FIFO and drops anything in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_block_with_rx_fifo_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_reg_offset,
    input  wire logic [31:0] i_write_value,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_data,
    output logic             o_write_error,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_irq_request,
    output logic             o_rx_dropped
);

    // Input register.
    logic        r_in_vld;
    logic [1:0]  r_mode;
    logic [7:0]  r_offset;
    logic [31:0] r_wval;
    logic [7:0]  r_rxb;

    // Register state.
    logic [31:0] r_sr;
    logic [31:0] r_brr;
    logic [31:0] r_cr1;
    logic [7:0]  r_tx_hold;
    logic        r_tx_busy;

    // Output register.
    logic        r_out_vld;
    logic [31:0] r_read_data;
    logic        r_write_error;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic        r_irq;
    logic        r_dropped;

    // Next values.
    logic [31:0] n_sr;
    logic [31:0] n_brr;
    logic [31:0] n_cr1;
    logic [7:0]  n_tx_hold;
    logic        n_tx_busy;
    logic [31:0] n_read_data;
    logic        n_write_error;
    logic        n_tx_valid;
    logic [7:0]  n_tx_byte;
    logic        n_irq;
    logic        n_dropped;

    logic                 w_fire;
    logic                 w_accept;
    logic                 w_ue;
    urb_pkg::t_fifo_req   w_fifo_req;
    urb_pkg::t_fifo_stat  w_fifo_stat;
    logic [7:0]           w_fifo_head;

    // The request in the input register is processed whenever the output
    // register is empty or is being emptied in this cycle.
    assign w_fire     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ue       = (r_cr1 & urb_pkg::CR1_UE) != '0;

    urb_rx_fifo u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_fifo_req),
        .o_stat  (w_fifo_stat),
        .o_head  (w_fifo_head)
    );

    // Single pass over the register state for the held request.
    always_comb begin
        n_sr          = r_sr;
        n_brr         = r_brr;
        n_cr1         = r_cr1;
        n_tx_hold     = r_tx_hold;
        n_tx_busy     = r_tx_busy;
        n_read_data   = '0;
        n_write_error = 1'b0;
        n_tx_valid    = 1'b0;
        n_tx_byte     = '0;
        n_irq         = 1'b0;
        n_dropped     = 1'b0;
        w_fifo_req    = '{push: 1'b0, pop: 1'b0, data: r_rxb};

        case (r_mode)
            urb_pkg::MODE_READ: begin
                case (r_offset)
                    urb_pkg::OFF_SR: begin
                        n_read_data = r_sr;
                    end
                    urb_pkg::OFF_DR: begin
                        // A read of DR pops the FIFO; RXNE falls with the
                        // last byte.
                        if (!w_fifo_stat.empty) begin
                            n_read_data    = {24'd0, w_fifo_head};
                            w_fifo_req.pop = w_fire;
                            if (w_fifo_stat.last) begin
                                n_sr = r_sr & ~urb_pkg::SR_RXNE;
                            end
                        end
                    end
                    urb_pkg::OFF_BRR: begin
                        n_read_data = r_brr;
                    end
                    urb_pkg::OFF_CR1: begin
                        n_read_data = r_cr1;
                    end
                    default: begin
                        n_read_data = '0;
                    end
                endcase
            end
            urb_pkg::MODE_WRITE: begin
                case (r_offset)
                    urb_pkg::OFF_SR: begin
                        // Status writes can only clear bits.
                        n_sr = r_sr & r_wval;
                    end
                    urb_pkg::OFF_DR: begin
                        if (w_ue) begin
                            n_tx_hold = 8'(r_wval & urb_pkg::BYTE_MASK);
                            n_tx_busy = 1'b1;
                            n_sr      = r_sr & ~(urb_pkg::SR_TXE | urb_pkg::SR_TC);
                        end
                    end
                    urb_pkg::OFF_BRR: begin
                        n_brr = r_wval;
                    end
                    urb_pkg::OFF_CR1: begin
                        n_cr1 = r_wval;
                    end
                    default: begin
                        n_write_error = 1'b1;
                    end
                endcase
            end
            urb_pkg::MODE_RX: begin
                if (w_fifo_stat.full) begin
                    n_dropped = 1'b1;
                end else begin
                    w_fifo_req.push = w_fire;
                    n_sr  = r_sr | urb_pkg::SR_RXNE;
                    n_irq = w_ue && ((r_cr1 & urb_pkg::CR1_RXNEIE) != '0);
                end
            end
            urb_pkg::MODE_TICK: begin
                if (r_tx_busy) begin
                    n_tx_busy  = 1'b0;
                    n_tx_valid = 1'b1;
                    n_tx_byte  = r_tx_hold;
                    n_sr       = r_sr | urb_pkg::SR_TXE | urb_pkg::SR_TC;
                    n_irq      = w_ue && ((r_cr1 & urb_pkg::CR1_TXEIE) != '0);
                end
            end
            default: begin
                n_read_data = '0;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_sr      <= urb_pkg::SR_RESET;
            r_brr     <= '0;
            r_cr1     <= '0;
            r_tx_hold <= '0;
            r_tx_busy <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
                r_sr      <= n_sr;
                r_brr     <= n_brr;
                r_cr1     <= n_cr1;
                r_tx_hold <= n_tx_hold;
                r_tx_busy <= n_tx_busy;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_offset <= i_reg_offset;
            r_wval   <= i_write_value;
            r_rxb    <= i_rx_byte;
        end
        if (w_fire) begin
            r_read_data   <= n_read_data;
            r_write_error <= n_write_error;
            r_tx_valid    <= n_tx_valid;
            r_tx_byte     <= n_tx_byte;
            r_irq         <= n_irq;
            r_dropped     <= n_dropped;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_read_data   = r_read_data;
    assign o_write_error = r_write_error;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_irq_request = r_irq;
    assign o_rx_dropped  = r_dropped;

`ifndef NO_ASSERTIONS
    // RXNE can only be set by a push, so an empty FIFO never shows it.
    a_empty_no_rxne: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_stat.empty |-> ((r_sr & urb_pkg::SR_RXNE) == '0))
        else $error("RXNE set while the receive FIFO is empty");

    // Pushes and pops are never issued against a full or empty FIFO.
    a_fifo_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fifo_req.push && w_fifo_stat.full) && !(w_fifo_req.pop && w_fifo_stat.empty))
        else $error("receive FIFO overrun or underrun");

    // Every processed request yields a result in the next cycle.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("processed request produced no result");
`endif

endmodule

`default_nettype wire
